/* rtl/core/x86_instruction_length_finder_defines.svh */
// assertion macros for the instruction length finder
`ifndef X86_INSTRUCTION_LENGTH_FINDER_DEFINES_SVH
`define X86_INSTRUCTION_LENGTH_FINDER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define ILF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ILF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ilf_pkg.sv */
// ----------------------------------------------------------------------------
// ilf_pkg
// types, constants and opcode tables for the instruction length finder
// ----------------------------------------------------------------------------
package ilf_pkg;

  localparam int unsigned MaxLength = 15;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       resync;
  } in_t;

  typedef struct packed {
    logic [3:0] length;
    logic       invalid;
  } out_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_OP2   = 3'd1,
    PH_MODRM = 3'd2,
    PH_TEST  = 3'd3,
    PH_SIB   = 3'd4,
    PH_TAIL  = 3'd5,
    PH_INT   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_PLAIN = 3'd0,
    K_MODRM = 3'd1,
    K_TWO   = 3'd2,
    K_INT   = 3'd3,
    K_TEST  = 3'd4
  } kind_t;

  // decode state carried between bytes
  typedef struct packed {
    phase_t     phase;
    logic [4:0] prefix_flags;
    logic       operand_is_short;
    logic       address_is_short;
    logic [7:0] saved_opcode;
    logic [4:0] bytes_taken;
    logic [2:0] pending_immediate;
    logic [2:0] pending_displacement;
  } state_t;

  localparam state_t StateClear = '{phase: PH_START, default: '0};

  // one-byte opcode classification
  typedef struct packed {
    kind_t      kind;
    logic [2:0] imm;
    logic [2:0] disp;
  } op_class_t;

  // 0F map: opcodes followed by modrm, and plain ones
  localparam logic [255:0] TwoModrm = {
    32'h77EEFFBF, 32'hFFAE00F7, 32'hFCFFF838, 32'hFFFF0000,
    32'hC37FCFFF, 32'hFFFEFFFF, 32'h0000FF0F, 32'hFFFF200F};
  localparam logic [255:0] TwoPlain = {
    32'h00000000, 32'h0000FF00, 32'h00000707, 32'h00000000,
    32'h00800000, 32'h00010000, 32'h003F0000, 32'h00000F50};

  function automatic op_class_t classify(input logic [7:0] op, input logic [2:0] opsz,
                                         input logic [2:0] adsz);
    op_class_t c;
    c = '{kind: K_PLAIN, imm: 3'd0, disp: 3'd0};
    if (op == 8'h0F) begin
      c.kind = K_TWO;
    end else if (op < 8'h40) begin
      if (op[2:0] < 3'd4) c.kind = K_MODRM;
      else if (op[2:0] == 3'd4) c.imm = 3'd1;
      else if (op[2:0] == 3'd5) c.imm = opsz;
    end else if (op == 8'h62 || op == 8'h63 || (op >= 8'h84 && op <= 8'h8F) ||
                 op == 8'hC4 || op == 8'hC5 || (op >= 8'hD0 && op <= 8'hD3) ||
                 (op >= 8'hD8 && op <= 8'hDF) || op == 8'hFE || op == 8'hFF) begin
      c.kind = K_MODRM;
    end else if (op == 8'h69 || op == 8'h81 || op == 8'hC7) begin
      c.kind = K_MODRM; c.imm = opsz;
    end else if (op == 8'h6B || op == 8'h80 || op == 8'h82 || op == 8'h83 ||
                 op == 8'hC0 || op == 8'hC1 || op == 8'hC6) begin
      c.kind = K_MODRM; c.imm = 3'd1;
    end else if (op == 8'h68 || op == 8'hA9 || (op >= 8'hB8 && op <= 8'hBF) ||
                 op == 8'hE8 || op == 8'hE9) begin
      c.imm = opsz;
    end else if (op == 8'h6A || (op >= 8'h70 && op <= 8'h7F) || op == 8'hA8 ||
                 (op >= 8'hB0 && op <= 8'hB7) || op == 8'hD4 || op == 8'hD5 ||
                 (op >= 8'hE0 && op <= 8'hE7) || op == 8'hEB) begin
      c.imm = 3'd1;
    end else if (op == 8'h9A || op == 8'hEA) begin
      c.imm = 3'(opsz + 3'd2);
    end else if (op >= 8'hA0 && op <= 8'hA3) begin
      c.disp = adsz;
    end else if (op == 8'hC2 || op == 8'hCA) begin
      c.imm = 3'd2;
    end else if (op == 8'hC8) begin
      c.imm = 3'd3;
    end else if (op == 8'hCD) begin
      c.kind = K_INT;
    end else if (op == 8'hF6 || op == 8'hF7) begin
      c.kind = K_TEST;
    end
    return c;
  endfunction

endpackage

/* rtl/core/ilf_step.sv */
// ----------------------------------------------------------------------------
// ilf_step
// combinational decode of one code byte against the current state
// ----------------------------------------------------------------------------
module ilf_step #(
  parameter int unsigned MAX_LENGTH = ilf_pkg::MaxLength
) (
  input  ilf_pkg::state_t cur,
  input  ilf_pkg::in_t    item,
  output ilf_pkg::state_t nxt,
  output logic            emit,
  output ilf_pkg::out_t   res
);

  ilf_pkg::state_t  s;
  ilf_pkg::state_t  w;
  ilf_pkg::op_class_t c;
  logic [7:0]       b;
  logic [2:0]       opsz;
  logic [2:0]       adsz;
  logic [1:0]       md;
  logic [2:0]       rm;
  logic             err;
  logic [4:0]       need;
  logic [5:0]       total;

  always_comb begin
    s    = item.resync ? ilf_pkg::StateClear : cur;
    b    = item.code_byte;
    opsz = s.operand_is_short ? 3'd2 : 3'd4;
    adsz = s.address_is_short ? 3'd2 : 3'd4;
    md   = b[7:6];
    rm   = b[2:0];
    c    = ilf_pkg::classify(b, opsz, adsz);
    w    = s;
    err  = 1'b0;
    w.bytes_taken = 5'(s.bytes_taken + 5'd1);
    unique case (s.phase)
      ilf_pkg::PH_START: begin
        if (b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
            b == 8'h64 || b == 8'h65) begin
          w.prefix_flags[4] = 1'b1;
        end else if (b == 8'h66) begin
          w.prefix_flags[0] = 1'b1; w.operand_is_short = 1'b1;
        end else if (b == 8'h67) begin
          w.prefix_flags[1] = 1'b1; w.address_is_short = 1'b1;
        end else if (b == 8'hF0) begin
          w.prefix_flags[2] = 1'b1;
        end else if (b == 8'hF2 || b == 8'hF3) begin
          w.prefix_flags[3] = 1'b1;
        end else begin
          w.saved_opcode         = b;
          w.pending_immediate    = c.imm;
          w.pending_displacement = c.disp;
          unique case (c.kind)
            ilf_pkg::K_TWO:   w.phase = ilf_pkg::PH_OP2;
            ilf_pkg::K_MODRM: w.phase = ilf_pkg::PH_MODRM;
            ilf_pkg::K_INT:   w.phase = ilf_pkg::PH_INT;
            ilf_pkg::K_TEST:  w.phase = ilf_pkg::PH_TEST;
            default:          w.phase = ilf_pkg::PH_TAIL;
          endcase
        end
      end
      ilf_pkg::PH_OP2: begin
        w.saved_opcode = b;
        if (b[7:4] == 4'h8) begin
          w.pending_immediate = opsz; w.phase = ilf_pkg::PH_TAIL;
        end else if (ilf_pkg::TwoModrm[b]) begin
          if ((b >= 8'h70 && b <= 8'h73) || b == 8'hA4 || b == 8'hAC || b == 8'hBA ||
              b == 8'hC2 || b == 8'hC4 || b == 8'hC5)
            w.pending_immediate = 3'd1;
          w.phase = ilf_pkg::PH_MODRM;
        end else if (ilf_pkg::TwoPlain[b]) begin
          w.phase = ilf_pkg::PH_TAIL;
        end else begin
          err = 1'b1;
        end
      end
      ilf_pkg::PH_MODRM, ilf_pkg::PH_TEST: begin
        if (s.phase == ilf_pkg::PH_TEST && b[5:3] == 3'd0)
          w.pending_immediate = s.saved_opcode[0] ? opsz : 3'd1;
        w.phase = ilf_pkg::PH_TAIL;
        if (md == 2'd3) begin
          w.pending_displacement = 3'd0;
        end else if (s.address_is_short) begin
          w.pending_displacement = (md == 2'd1) ? 3'd1 : (md == 2'd2) ? 3'd2 :
                                   (rm == 3'd6) ? 3'd2 : 3'd0;
        end else begin
          w.pending_displacement = (md == 2'd1) ? 3'd1 : (md == 2'd2) ? 3'd4 : 3'd0;
          if (rm == 3'd4) w.phase = ilf_pkg::PH_SIB;
          else if (rm == 3'd5 && md == 2'd0) w.pending_displacement = 3'd4;
        end
      end
      ilf_pkg::PH_SIB: begin
        if (rm == 3'd5 && s.pending_displacement == 3'd0) w.pending_displacement = 3'd4;
        w.phase = ilf_pkg::PH_TAIL;
      end
      ilf_pkg::PH_INT: begin
        w.pending_immediate = (b == 8'h20) ? 3'd4 : 3'd0;
        w.phase = ilf_pkg::PH_TAIL;
      end
      default: begin
        if (s.pending_displacement != 3'd0)
          w.pending_displacement = s.pending_displacement - 3'd1;
        else if (s.pending_immediate != 3'd0)
          w.pending_immediate = s.pending_immediate - 3'd1;
        w.phase = ilf_pkg::PH_TAIL;
      end
    endcase

    // fewest bytes still certainly due
    priority case (w.phase)
      ilf_pkg::PH_TAIL:
        need = 5'(w.pending_displacement) + 5'(w.pending_immediate);
      ilf_pkg::PH_MODRM, ilf_pkg::PH_TEST:
        need = 5'd1 + 5'(w.pending_immediate);
      ilf_pkg::PH_SIB:
        need = 5'd1 + 5'(w.pending_displacement) + 5'(w.pending_immediate);
      default:
        need = 5'd1;
    endcase
    total = 6'(w.bytes_taken) + 6'(need);

    emit = 1'b0;
    res  = '{length: w.bytes_taken[3:0], invalid: 1'b0};
    nxt  = w;
    if (err || total > 6'(MAX_LENGTH)) begin
      emit = 1'b1;
      res  = '{length: 4'd0, invalid: 1'b1};
      nxt  = ilf_pkg::StateClear;
    end else if (w.phase == ilf_pkg::PH_TAIL && need == 5'd0) begin
      emit = 1'b1;
      nxt  = ilf_pkg::StateClear;
    end
  end

endmodule

/* rtl/core/x86_instruction_length_finder.sv */
// a result is registered in the output register when its last byte is accepted
// throughput: one code byte per cycle unless stalled; a single table lookup pass
// input stalls only when the output register holds an untaken result
// reset (synchronous, active high) clears the decode state and the output valid
// ----------------------------------------------------------------------------
// x86_instruction_length_finder
// finds instruction boundaries in a byte-serial 32-bit x86 code stream
// ----------------------------------------------------------------------------
module x86_instruction_length_finder #(
  parameter int unsigned MAX_LENGTH = ilf_pkg::MaxLength
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ilf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ilf_pkg::out_t out_data
);

  // decode state between bytes
  ilf_pkg::state_t state;
  ilf_pkg::state_t state_next;
  logic            emit;
  ilf_pkg::out_t   res;
  logic            in_fire;

  ilf_step #(.MAX_LENGTH(MAX_LENGTH)) u_step (
    .cur  (state),
    .item (in_data),
    .nxt  (state_next),
    .emit (emit),
    .res  (res)
  );

  // accept whenever the result register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ilf_pkg::StateClear;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) state <= state_next;
      if (in_fire) out_valid <= emit;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && emit) out_data <= res;
  end

endmodule

/* rtl/core/ilf_checker.sv */
// ----------------------------------------------------------------------------
// ilf_checker
// port-level checks for the instruction length finder
// ----------------------------------------------------------------------------
`include "x86_instruction_length_finder_defines.svh"

module ilf_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ilf_pkg::out_t out_data
);

  `ILF_ASSERT_IMPL(a_inv_len, clk, rst, out_valid && out_data.invalid, out_data.length == 4'd0, "invalid result with nonzero length")
  `ILF_ASSERT_IMPL(a_ok_len, clk, rst, out_valid && !out_data.invalid, out_data.length != 4'd0, "valid result with zero length")
  `ILF_ASSERT_IMPL(a_ready, clk, rst, !out_valid || out_ready, in_ready, "input stalled with free output")
  `ILF_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind x86_instruction_length_finder ilf_checker u_ilf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/tb_x86_instruction_length_finder.sv */
// ----------------------------------------------------------------------------
// tb_x86_instruction_length_finder
// byte-serial stream test: a scoreboard predicts each instruction length or
// error from its own decoder model and checks every output transaction
// ----------------------------------------------------------------------------
module tb_x86_instruction_length_finder;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  ilf_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ilf_pkg::out_t  out_data;

  x86_instruction_length_finder dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // 0F opcode maps, bit n set for second byte n
  localparam logic [255:0] ModrmMap = {
    32'h77EEFFBF, 32'hFFAE00F7, 32'hFCFFF838, 32'hFFFF0000,
    32'hC37FCFFF, 32'hFFFEFFFF, 32'h0000FF0F, 32'hFFFF200F};
  localparam logic [255:0] PlainMap = {
    32'h00000000, 32'h0000FF00, 32'h00000707, 32'h00000000,
    32'h00800000, 32'h00010000, 32'h003F0000, 32'h00000F50};

  // decoder model state
  ilf_pkg::phase_t dec_phase;
  logic            dec_opshort, dec_adshort;
  logic [7:0]      dec_opcode;
  logic [4:0]      dec_count;
  int              dec_imm, dec_disp;

  ilf_pkg::in_t  pending_bytes[$];
  ilf_pkg::out_t expected_lengths[$];

  int   mismatches = 0;
  int   send_idle_pct = 30;
  int   recv_idle_pct = 53;
  bit   hold_receiver = 1'b0;
  int   quiet_cycles = 0;
  logic in_ready_q = 1'b0;

  task automatic clear_decoder();
    dec_phase = ilf_pkg::PH_START; dec_opshort = 0; dec_adshort = 0;
    dec_opcode = '0; dec_count = '0; dec_imm = 0; dec_disp = 0;
  endtask

  // classify a first opcode byte; sets pending tail counts, returns next phase
  function automatic ilf_pkg::phase_t first_opcode(input logic [7:0] op, input int osz,
                                                   input int asz);
    dec_imm = 0; dec_disp = 0;
    if (op == 8'h0F) return ilf_pkg::PH_OP2;
    if (op < 8'h40) begin
      if (op[2:0] < 4) return ilf_pkg::PH_MODRM;
      if (op[2:0] == 4) dec_imm = 1;
      else if (op[2:0] == 5) dec_imm = osz;
      return ilf_pkg::PH_TAIL;
    end
    case (op) inside
      8'h62, 8'h63, [8'h84:8'h8F], 8'hC4, 8'hC5, [8'hD0:8'hD3], [8'hD8:8'hDF],
      8'hFE, 8'hFF: return ilf_pkg::PH_MODRM;
      8'h69, 8'h81, 8'hC7: begin dec_imm = osz; return ilf_pkg::PH_MODRM; end
      8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6: begin
        dec_imm = 1; return ilf_pkg::PH_MODRM;
      end
      8'h68, 8'hA9, [8'hB8:8'hBF], 8'hE8, 8'hE9: dec_imm = osz;
      8'h6A, [8'h70:8'h7F], 8'hA8, [8'hB0:8'hB7], 8'hD4, 8'hD5, [8'hE0:8'hE7], 8'hEB:
        dec_imm = 1;
      8'h9A, 8'hEA: dec_imm = osz + 2;
      [8'hA0:8'hA3]: dec_disp = asz;
      8'hC2, 8'hCA: dec_imm = 2;
      8'hC8: dec_imm = 3;
      8'hCD: return ilf_pkg::PH_INT;
      8'hF6, 8'hF7: return ilf_pkg::PH_TEST;
      default: ;
    endcase
    return ilf_pkg::PH_TAIL;
  endfunction

  // advance the model by one byte; queue a length or error when one is due
  task automatic decode_byte(input ilf_pkg::in_t item);
    logic [7:0] b;
    int osz, asz, need;
    bit err;
    ilf_pkg::out_t r;
    b = item.code_byte;
    err = 0;
    if (item.resync) clear_decoder();
    dec_count = dec_count + 5'd1;
    osz = dec_opshort ? 2 : 4;
    asz = dec_adshort ? 2 : 4;
    case (dec_phase)
      ilf_pkg::PH_START: begin
        if (b == 8'h66) dec_opshort = 1;
        else if (b == 8'h67) dec_adshort = 1;
        else if (!(b inside {8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF0,
                             8'hF2, 8'hF3})) begin
          dec_opcode = b;
          dec_phase = first_opcode(b, osz, asz);
        end
      end
      ilf_pkg::PH_OP2: begin
        dec_opcode = b;
        if (b[7:4] == 4'h8) begin
          dec_imm = osz; dec_phase = ilf_pkg::PH_TAIL;
        end else if (ModrmMap[b]) begin
          if (b inside {[8'h70:8'h73], 8'hA4, 8'hAC, 8'hBA, 8'hC2, 8'hC4, 8'hC5})
            dec_imm = 1;
          dec_phase = ilf_pkg::PH_MODRM;
        end else if (PlainMap[b]) dec_phase = ilf_pkg::PH_TAIL;
        else err = 1;  // undefined two-byte opcode
      end
      ilf_pkg::PH_MODRM, ilf_pkg::PH_TEST: begin
        // test group reg field 0 carries an immediate
        if (dec_phase == ilf_pkg::PH_TEST && b[5:3] == 3'd0) dec_imm = dec_opcode[0] ? osz : 1;
        dec_phase = ilf_pkg::PH_TAIL;
        if (b[7:6] == 2'd3) dec_disp = 0;
        else if (dec_adshort)
          dec_disp = b[7:6] == 2'd1 ? 1 : b[7:6] == 2'd2 ? 2 : (b[2:0] == 3'd6 ? 2 : 0);
        else begin
          dec_disp = b[7:6] == 2'd1 ? 1 : b[7:6] == 2'd2 ? 4 : 0;
          if (b[2:0] == 3'd4) dec_phase = ilf_pkg::PH_SIB;
          else if (b[2:0] == 3'd5 && b[7:6] == 2'd0) dec_disp = 4;
        end
      end
      ilf_pkg::PH_SIB: begin
        if (b[2:0] == 3'd5 && dec_disp == 0) dec_disp = 4;
        dec_phase = ilf_pkg::PH_TAIL;
      end
      ilf_pkg::PH_INT: begin
        dec_imm = (b == 8'h20) ? 4 : 0;  // int 20h carries four more bytes
        dec_phase = ilf_pkg::PH_TAIL;
      end
      default: begin
        if (dec_disp > 0) dec_disp--;
        else if (dec_imm > 0) dec_imm--;
      end
    endcase
    if (!err) begin
      if (dec_phase == ilf_pkg::PH_TAIL) need = dec_disp + dec_imm;
      else if (dec_phase inside {ilf_pkg::PH_MODRM, ilf_pkg::PH_TEST}) need = 1 + dec_imm;
      else if (dec_phase == ilf_pkg::PH_SIB) need = 1 + dec_disp + dec_imm;
      else need = 1;
      if (int'(dec_count) + need > ilf_pkg::MaxLength) err = 1;
      else if (dec_phase == ilf_pkg::PH_TAIL && need == 0) begin
        r.length = dec_count[3:0]; r.invalid = 1'b0;
        expected_lengths.push_back(r);
        clear_decoder();
      end
    end
    if (err) begin
      r.length = '0; r.invalid = 1'b1;
      expected_lengths.push_back(r);
      clear_decoder();
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input bit rs = 0);
    ilf_pkg::in_t t;
    t.code_byte = b; t.resync = rs;
    pending_bytes.push_back(t);
  endtask

  function automatic logic [7:0] pick_prefix();
    logic [7:0] p[10] = '{8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'h66, 8'h67,
                          8'hF0, 8'hF3};
    return p[$urandom_range(9)];
  endfunction

  // a well formed-ish instruction: prefixes, opcode, then random tail bytes
  task automatic push_instruction();
    int n;
    n = $urandom_range(99) < 30 ? $urandom_range(3) : 0;
    if ($urandom_range(99) < 2) n = $urandom_range(16);
    repeat (n) push_byte(pick_prefix());
    if ($urandom_range(99) < 20) push_byte(8'h0F);
    else if ($urandom_range(99) < 5) begin
      push_byte(8'hCD);
      push_byte($urandom_range(99) < 50 ? 8'h20 : 8'($urandom));
    end
    push_byte(8'($urandom), $urandom_range(99) < 2);
    repeat (12) push_byte(8'($urandom));  // extra bytes flow into the next instruction
  endtask

  // driver: offers bytes from the pending queue, changes at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_q) begin
        decode_byte(in_data);
        void'(pending_bytes.pop_front());
      end
      if ((!in_valid || in_ready_q) && pending_bytes.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_bytes[0];
      end else if (!in_valid || in_ready_q) in_valid <= 1'b0;
      out_ready <= !hold_receiver && $urandom_range(99) >= recv_idle_pct;
    end
  end

  // handshake outcome captured at the rising edge
  always @(posedge clk) begin
    in_ready_q <= in_valid && in_ready;
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // monitor: compares each output transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_lengths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result len=%0d inv=%0b",
                                       out_data.length, out_data.invalid);
      end else begin
        ilf_pkg::out_t e;
        e = expected_lengths.pop_front();
        if (e !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected len=%0d inv=%0b, got len=%0d inv=%0b",
                     e.length, e.invalid, out_data.length, out_data.invalid);
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (quiet_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    repeat (2) @(posedge clk);
    while (expected_lengths.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clear_decoder();
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    // directed: prefixes, sib, int 20h, two-byte 0F opcode, too many prefixes, resync
    push_byte(8'h90);
    push_byte(8'h66); push_byte(8'h67); push_byte(8'hF0); push_byte(8'h2E);
    push_byte(8'h81); push_byte(8'h84); push_byte(8'h25);
    repeat (6) push_byte(8'hFF);
    push_byte(8'hCD); push_byte(8'h20); repeat (4) push_byte(8'h00);
    push_byte(8'h0F); push_byte(8'h04);
    push_byte(8'hF7); push_byte(8'h00); push_byte(8'h01, 1);
    repeat (15) push_byte(8'hF2);
    push_byte(8'h00); push_byte(8'h00);
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 53; recv_idle_pct = 30; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 0) begin
        // long receiver hold-off while bytes keep coming
        hold_receiver = 1'b1;
        repeat (35) push_instruction();
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
      while (pending_bytes.size() < 500) push_instruction();
      wait_drained();  // sender pause until all results are in
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_lengths.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
